/* sv/tlv_pkg.sv */
`default_nettype none
package tlv_pkg;

  localparam int CITY_W     = 16;
  localparam int COORD_W    = 24;
  localparam int CNT_W      = 17;
  localparam int LEN_W      = 48;
  localparam int MAX_CITIES = 65536;
  localparam int EPOCH_W    = 8;
  localparam int ROOT_W     = COORD_W + 1;
  localparam int DSQ_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int EDGE_W     = ROOT_W + 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CITIES = 1'd1;

  localparam logic [CNT_W-1:0] CITY_COUNT_RST = CNT_W'(MAX_CITIES);

  typedef struct packed {
    logic [CITY_W-1:0]         city;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_city;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] path_len;
    logic             feasible;
    logic [CNT_W-1:0] cities_seen;
  } out_word_t;

  typedef struct packed {
    logic              rd_en;
    logic              mark;
    logic              tour_done;
    logic [CITY_W-1:0] addr;
  } visit_req_t;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [EDGE_W-1:0] e);
    logic [LEN_W:0] s;
    s = {1'b0, a} + (LEN_W+1)'(e);
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/tour_length_and_validity_unit.sv */
`default_nettype none
// Tour length and feasibility checker. Cities arrive one word at a time. A word that
// opens a tour passes through the visited-store lookup, the count update and the
// return to idle; every other word also waits for the edge unit that starts on
// acceptance: operand difference, squaring, sum, 25 root iterations, rounding, then
// the hand-back of the length. The word marked last then runs the closing edge before
// its result word is loaded. One city is in work at a time; a finished result waits in
// the output register while the next tour streams in. The visited store keeps a tour
// tag per city, so it is not cleared between tours; a clearing pass over the store runs
// after reset and again after every 255th tour, during which no city word is taken
// (configuration writes are). Configure city_count and min_cities while idle.
module tour_length_and_validity_unit
  import tlv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CNT_W-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EDGE  = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                state_r;
  logic [CNT_W-1:0]          city_count_r, min_cities_r;
  logic [CITY_W-1:0]         city_r;
  logic signed [COORD_W-1:0] x_r, y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                      last_r, pend_r, at_start_r, ok_r;
  logic [LEN_W-1:0]          length_r;
  logic [CNT_W-1:0]          seen_cnt_r;
  logic                      out_valid_r;
  out_word_t                 out_word_r;

  logic                      in_fire, edge_start, edge_done, edge_ok, out_load;
  logic                      visit_seen, visit_busy, fail;
  logic [EDGE_W-1:0]         edge_len;
  logic signed [COORD_W-1:0] ea_x, ea_y, eb_x, eb_y;
  visit_req_t                vreq;

  assign in_ready = (state_r == S_IDLE) && !visit_busy;
  assign in_fire  = in_valid && in_ready;
  assign edge_ok  = !pend_r || edge_done;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign fail     = ({1'b0, city_r} >= city_count_r) || (seen_cnt_r >= city_count_r)
                    || visit_seen;

  assign edge_start = (in_fire && !at_start_r) || (state_r == S_EDGE && edge_ok && last_r);
  assign ea_x = (state_r == S_IDLE) ? prev_x_r : x_r;
  assign ea_y = (state_r == S_IDLE) ? prev_y_r : y_r;
  assign eb_x = (state_r == S_IDLE) ? in_word.coord_x : first_x_r;
  assign eb_y = (state_r == S_IDLE) ? in_word.coord_y : first_y_r;

  always_comb begin
    vreq.rd_en     = in_fire;
    vreq.mark      = (state_r == S_CHECK) && ok_r && !fail;
    vreq.tour_done = out_load;
    vreq.addr      = in_fire ? in_word.city : city_r;
  end

  tlv_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (edge_start),
    .ax    (ea_x),
    .ay    (ea_y),
    .bx    (eb_x),
    .by    (eb_y),
    .done  (edge_done),
    .len   (edge_len)
  );

  tlv_visit u_visit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (vreq),
    .seen (visit_seen),
    .busy (visit_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CITY_COUNT_RST;
      min_cities_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CITY_COUNT: city_count_r <= cfg_wdata;
        CFG_MIN_CITIES: min_cities_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      city_r <= in_word.city;
      x_r    <= in_word.coord_x;
      y_r    <= in_word.coord_y;
      last_r <= in_word.last_city;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      at_start_r  <= 1'b1;
      pend_r      <= 1'b0;
      ok_r        <= 1'b1;
      seen_cnt_r  <= '0;
      length_r    <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (at_start_r) begin
              first_x_r <= in_word.coord_x;
              first_y_r <= in_word.coord_y;
            end
            prev_x_r   <= in_word.coord_x;
            prev_y_r   <= in_word.coord_y;
            pend_r     <= !at_start_r;
            at_start_r <= 1'b0;
            state_r    <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ok_r) begin
            if (fail) begin
              ok_r <= 1'b0;
            end else begin
              seen_cnt_r <= seen_cnt_r + 1'b1;
            end
          end
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          if (edge_ok) begin
            if (pend_r) begin
              length_r <= sat_add(length_r, edge_len);
            end
            pend_r  <= 1'b0;
            state_r <= last_r ? S_CLOSE : S_IDLE;
          end
        end
        S_CLOSE: begin
          if (edge_done) begin
            length_r <= sat_add(length_r, edge_len);
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            at_start_r  <= 1'b1;
            ok_r        <= 1'b1;
            seen_cnt_r  <= '0;
            length_r    <= '0;
            first_x_r   <= '0;
            first_y_r   <= '0;
            prev_x_r    <= '0;
            prev_y_r    <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.path_len    <= length_r;
      out_word_r.feasible    <= ok_r && (seen_cnt_r >= min_cities_r);
      out_word_r.cities_seen <= seen_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
    vreq.mark |=> seen_cnt_r == $past(seen_cnt_r) + 1'b1)
    else $error("visited mark without count step");
  a_check_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> $past(state_r) == S_IDLE && $past(in_fire))
    else $error("lookup stage entered without a word");
  a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    visit_busy |-> state_r == S_IDLE)
    else $error("clearing pass overlaps a tour");

endmodule
`default_nettype wire

/* sv/tlv_edge.sv */
`default_nettype none
module tlv_edge
  import tlv_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [COORD_W-1:0] ax,
  input  wire logic signed [COORD_W-1:0] ay,
  input  wire logic signed [COORD_W-1:0] bx,
  input  wire logic signed [COORD_W-1:0] by,
  output logic                           done,
  output logic [EDGE_W-1:0]              len
);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_SQ   = 3'd1;
  localparam logic [2:0] E_SUM  = 3'd2;
  localparam logic [2:0] E_ROOT = 3'd3;
  localparam logic [2:0] E_RND  = 3'd4;
  localparam logic [2:0] E_DONE = 3'd5;
  localparam int CNT_BITS = $clog2(ROOT_W);

  logic [2:0]          state_r, state_nxt;
  logic [ROOT_W-1:0]   dx_r, dy_r;
  logic [DSQ_W-1:0]    sqx_r, sqy_r, d_r;
  logic [ROOT_W-1:0]   root_r;
  logic [REM_W-1:0]    rem_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [EDGE_W-1:0]   len_r;

  logic signed [ROOT_W-1:0] diff_x, diff_y;
  logic [REM_W-1:0]         rem_sh, trial;

  assign diff_x = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
  assign diff_y = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};
  assign rem_sh = {rem_r[REM_W-3:0], d_r[DSQ_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE, E_DONE: if (start) state_nxt = E_SQ;
      E_SQ:           state_nxt = E_SUM;
      E_SUM:          state_nxt = E_ROOT;
      E_ROOT:         if (cnt_r == '0) state_nxt = E_RND;
      E_RND:          state_nxt = E_DONE;
      default:        state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      E_IDLE, E_DONE: begin
        dx_r <= diff_x[ROOT_W-1] ? ROOT_W'(-diff_x) : ROOT_W'(diff_x);
        dy_r <= diff_y[ROOT_W-1] ? ROOT_W'(-diff_y) : ROOT_W'(diff_y);
      end
      E_SQ: begin
        sqx_r <= dx_r * dx_r;
        sqy_r <= dy_r * dy_r;
      end
      E_SUM: begin
        d_r    <= sqx_r + sqy_r;
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= CNT_BITS'(ROOT_W - 1);
      end
      E_ROOT: begin
        d_r   <= {d_r[DSQ_W-3:0], 2'b00};
        cnt_r <= cnt_r - 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      E_RND: begin
        len_r <= {1'b0, root_r} + EDGE_W'(rem_r > REM_W'(root_r));
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == E_DONE);
  assign len  = len_r;

  a_start_sq: assert property (@(posedge clk) disable iff (!rst_n)
    start && (state_r == E_IDLE || state_r == E_DONE) |=> state_r == E_SQ)
    else $error("edge unit ignored start");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_RND |-> rem_r <= REM_W'({root_r, 1'b0}))
    else $error("root remainder out of bound");
  a_root_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_ROOT && cnt_r == '0 |=> state_r == E_RND)
    else $error("root iteration overran");

endmodule
`default_nettype wire

/* sv/tlv_visit.sv */
`default_nettype none
module tlv_visit
  import tlv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire visit_req_t req,
  output logic            seen,
  output logic            busy
);

  logic [EPOCH_W-1:0] mem [MAX_CITIES];
  logic [EPOCH_W-1:0] rd_q_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic               busy_r;
  logic [CITY_W-1:0]  clr_cnt_r;

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.mark) begin
      mem[req.addr] <= epoch_r;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.addr];
    end
  end

  // epoch advances per tour; sweep to zero when it wraps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      epoch_r   <= EPOCH_W'(1);
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CITY_W'(MAX_CITIES - 1)) begin
        busy_r <= 1'b0;
      end
    end else if (req.tour_done) begin
      if (epoch_r == '1) begin
        busy_r    <= 1'b1;
        clr_cnt_r <= '0;
        epoch_r   <= EPOCH_W'(1);
      end else begin
        epoch_r <= epoch_r + 1'b1;
      end
    end
  end

  assign seen = (rd_q_r == epoch_r);
  assign busy = busy_r;

  a_epoch_nz: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch reached the cleared value");
  a_wrap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && req.tour_done && epoch_r == '1 |=> busy_r)
    else $error("epoch wrapped without a sweep");
  a_no_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.mark && !req.rd_en)
    else $error("access during sweep");

endmodule
`default_nettype wire
